### rtl/rraps_pkg.sv
package rraps_pkg;

    localparam int MAX_DIM = 4096;
    localparam int SUBSAMPLES_PER_AXIS = 4;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIM_W = 13;
    localparam int POS_W = 12;
    localparam int SCR_W = 17;
    localparam int COLOR_W = 32;
    localparam int DELTA_W = 14;
    localparam int SQ_W = 2 * DELTA_W;
    localparam int LIM_W = 30;
    localparam int COUNT_W = 5;

    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(MAX_DIM);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_RECT_WIDTH    = 3'd2,
        CFG_RECT_HEIGHT   = 3'd3,
        CFG_CORNER_RADIUS = 3'd4,
        CFG_FILL_COLOR    = 3'd5
    } t_cfg_idx;

    typedef logic [SQ_W-1:0] t_sq_row [SUBSAMPLES_PER_AXIS];

    function automatic logic [7:0] coverage_of(input logic [COUNT_W-1:0] n);
        logic [7:0] cov;
        case (n)
            5'd0:  cov = 8'd0;
            5'd1:  cov = 8'd16;
            5'd2:  cov = 8'd32;
            5'd3:  cov = 8'd48;
            5'd4:  cov = 8'd64;
            5'd5:  cov = 8'd80;
            5'd6:  cov = 8'd96;
            5'd7:  cov = 8'd112;
            5'd8:  cov = 8'd128;
            5'd9:  cov = 8'd143;
            5'd10: cov = 8'd159;
            5'd11: cov = 8'd175;
            5'd12: cov = 8'd191;
            5'd13: cov = 8'd207;
            5'd14: cov = 8'd223;
            5'd15: cov = 8'd239;
            5'd16: cov = 8'd255;
            default: cov = 8'd0;
        endcase
        return cov;
    endfunction

endpackage

### rtl/rraps_in_if.sv
interface rraps_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_row;
    logic [11:0] pixel_column;

    modport source (output valid, output pixel_row, output pixel_column, input ready);
    modport sink (input valid, input pixel_row, input pixel_column, output ready);
endinterface

### rtl/rraps_out_if.sv
interface rraps_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] screen_x;
    logic signed [16:0] screen_y;
    logic [31:0]        rgba;

    modport source (output valid, output screen_x, output screen_y, output rgba,
                    input ready);
    modport sink (input valid, input screen_x, input screen_y, input rgba,
                  output ready);
endinterface

### rtl/rounded_rect_aa_pixel_shader.sv
// Channel   Direction  Handshake      Payload
// i_pix     in         valid / ready  pixel_row, pixel_column
// o_pix     out        valid / ready  screen_x, screen_y, rgba
// i_cfg_*   in         write enable   register index, write data
//
// Six register stages: one item enters every cycle while no stall holds the pipeline; its result leaves from the sixth.
// The depth is set by the sub-sample squarers, the coverage count and the alpha multiply.
// Pixels outside the rectangle, or corner pixels with no covered sample, leave no result and take no slot.
// Each stage holds its item while the next is full, so a stall at the output backs up.
// Reset is synchronous; it resets the configuration and derived registers and clears all stage valid bits.
// Derived size and radius registers are registered from a register write; r_lim is registered from r_rad.
module rounded_rect_aa_pixel_shader (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rraps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rraps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    rraps_in_if.sink                            i_pix,
    rraps_out_if.source                         o_pix
);
    import rraps_pkg::*;

    logic signed [15:0]   r_origin_x;
    logic signed [15:0]   r_origin_y;
    logic [DIM_W-1:0]     r_rect_width;
    logic [DIM_W-1:0]     r_rect_height;
    logic [POS_W-1:0]     r_corner_radius;
    logic [COLOR_W-1:0]   r_fill_color;

    logic [DIM_W-1:0]     r_w;
    logic [DIM_W-1:0]     r_h;
    logic [POS_W-1:0]     r_rad;
    logic [LIM_W-1:0]     r_lim;
    logic [DIM_W-1:0]     n_w;
    logic [DIM_W-1:0]     n_h;
    logic [POS_W-1:0]     n_rad;
    logic [14:0]          rad_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_rect_width    <= DIM_W'(1);
            r_rect_height   <= DIM_W'(1);
            r_corner_radius <= '0;
            r_fill_color    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X:      r_origin_x      <= i_cfg_data[15:0];
                CFG_ORIGIN_Y:      r_origin_y      <= i_cfg_data[15:0];
                CFG_RECT_WIDTH:    r_rect_width    <= i_cfg_data[DIM_W-1:0];
                CFG_RECT_HEIGHT:   r_rect_height   <= i_cfg_data[DIM_W-1:0];
                CFG_CORNER_RADIUS: r_corner_radius <= i_cfg_data[POS_W-1:0];
                CFG_FILL_COLOR:    r_fill_color    <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_w = (r_rect_width > DIM_CAP) ? DIM_CAP : r_rect_width;
        n_h = (r_rect_height > DIM_CAP) ? DIM_CAP : r_rect_height;
        n_rad = r_corner_radius;
        if (n_rad > n_w[DIM_W-1:1]) begin
            n_rad = n_w[DIM_W-1:1];
        end
        if (n_rad > n_h[DIM_W-1:1]) begin
            n_rad = n_h[DIM_W-1:1];
        end
        rad_scaled = {r_rad, 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= DIM_W'(1);
            r_h   <= DIM_W'(1);
            r_rad <= '0;
            r_lim <= '0;
        end else begin
            r_w   <= n_w;
            r_h   <= n_h;
            r_rad <= n_rad;
            r_lim <= LIM_W'(rad_scaled) * LIM_W'(rad_scaled);
        end
    end

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !r_v6 || o_pix.ready;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign i_pix.ready = rdy1;

    logic [POS_W-1:0] r_row1, r_col1;

    logic [POS_W-1:0]    mrow, mcol;
    logic                in_rect, corner;
    logic [14:0]         dy_full, dx_full;
    logic [SCR_W-1:0]    scr_x, scr_y;

    logic                r_corner2, r_corner3, r_corner4, r_corner5;
    logic [DELTA_W-1:0]  r_dx2, r_dy2;
    logic [SCR_W-1:0]    r_sx2, r_sy2, r_sx3, r_sy3, r_sx4, r_sy4, r_sx5, r_sy5;
    t_sq_row             r_sqx3, r_sqy3;
    t_sq_row             n_sqx, n_sqy;
    logic [COUNT_W-1:0]  r_n4;
    logic [15:0]         hits;
    logic [15:0]         r_prod5;
    logic [15:0]         n_prod;
    logic [7:0]          base;
    logic                keep4;
    logic [16:0]         quot_sum;
    logic [7:0]          alpha;
    logic [SCR_W-1:0]    r_sx6, r_sy6;
    logic [COLOR_W-1:0]  r_color6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_row1 <= i_pix.pixel_row;
            r_col1 <= i_pix.pixel_column;
        end
    end

    always_comb begin
        in_rect = ({1'b0, r_row1} < r_h) && ({1'b0, r_col1} < r_w);
        mrow = (r_row1 < r_rad) ? r_row1 : POS_W'(r_h - DIM_W'(1) - {1'b0, r_row1});
        mcol = (r_col1 < r_rad) ? r_col1 : POS_W'(r_w - DIM_W'(1) - {1'b0, r_col1});
        corner = (r_rad != '0) && (mrow < r_rad) && (mcol < r_rad);
        dy_full = {r_rad, 3'b000} - {mrow, 3'b000} - 15'd1;
        dx_full = {r_rad, 3'b000} - {mcol, 3'b000} - 15'd1;
        scr_x = SCR_W'(r_origin_x) + SCR_W'(r_col1);
        scr_y = SCR_W'(r_origin_y) + SCR_W'(r_row1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1 && in_rect;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_corner2 <= corner;
            r_dx2     <= dx_full[DELTA_W-1:0];
            r_dy2     <= dy_full[DELTA_W-1:0];
            r_sx2     <= scr_x;
            r_sy2     <= scr_y;
        end
    end

    always_comb begin
        for (int s = 0; s < SUBSAMPLES_PER_AXIS; s++) begin
            logic [DELTA_W-1:0] dxs, dys;
            dxs = r_dx2 - DELTA_W'(2 * s);
            dys = r_dy2 - DELTA_W'(2 * s);
            n_sqx[s] = dxs * dxs;
            n_sqy[s] = dys * dys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_corner3 <= r_corner2;
            r_sqx3    <= n_sqx;
            r_sqy3    <= n_sqy;
            r_sx3     <= r_sx2;
            r_sy3     <= r_sy2;
        end
    end

    always_comb begin
        for (int sy = 0; sy < SUBSAMPLES_PER_AXIS; sy++) begin
            for (int sx = 0; sx < SUBSAMPLES_PER_AXIS; sx++) begin
                hits[sy * SUBSAMPLES_PER_AXIS + sx] =
                    (LIM_W'(r_sqx3[sx]) + LIM_W'(r_sqy3[sy])) <= r_lim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_corner4 <= r_corner3;
            r_n4      <= COUNT_W'($countones(hits));
            r_sx4     <= r_sx3;
            r_sy4     <= r_sy3;
        end
    end

    always_comb begin
        base = (r_fill_color[7:0] == 8'd0) ? 8'd255 : r_fill_color[7:0];
        n_prod = base * coverage_of(r_n4) + 16'd127;
        keep4 = !(r_corner4 && (r_n4 == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (rdy5) begin
            r_v5 <= r_v4 && keep4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_corner5 <= r_corner4;
            r_prod5   <= n_prod;
            r_sx5     <= r_sx4;
            r_sy5     <= r_sy4;
        end
    end

    // Division by 255 of a 16-bit value: (x + 1 + x / 256) / 256.
    always_comb begin
        quot_sum = {1'b0, r_prod5} + 17'd1 + 17'(r_prod5[15:8]);
        alpha = quot_sum[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (rdy6) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r_sx6    <= r_sx5;
            r_sy6    <= r_sy5;
            r_color6 <= r_corner5 ? {r_fill_color[31:8], alpha} : r_fill_color;
        end
    end

    assign o_pix.valid       = r_v6;
    assign o_pix.screen_x    = r_sx6;
    assign o_pix.screen_y    = r_sy6;
    assign o_pix.rgba        = r_color6;

endmodule

### rtl/rraps_checker.sv
module rraps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [16:0] i_screen_x,
    input logic [16:0] i_screen_y,
    input logic [31:0] i_rgba
);

    // A cleared pipeline shows no result right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    // With no result waiting, every stage can advance, so an item is always taken.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while the output is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_screen_x) && $stable(i_screen_y)
            && $stable(i_rgba))
        else $error("stalled result changed");

endmodule

bind rounded_rect_aa_pixel_shader rraps_checker u_rraps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_pix.valid),
    .i_out_ready   (o_pix.ready),
    .i_screen_x    (o_pix.screen_x),
    .i_screen_y    (o_pix.screen_y),
    .i_rgba        (o_pix.rgba)
);
